FILE: src/bmrb_pkg.sv
// Package for the mailbox register block: payload structs, codes, helpers.
// No dependencies.
package bmrb_pkg;

    localparam int MAILBOXES_PER_DIRECTION_DEF = 4;
    localparam int DATA_BYTES_DEF = 8;
    localparam int NUM_BOX = 8;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_DONE  = 2'd2;

    localparam logic [1:0] OFF_CTRL = 2'd0;
    localparam logic [1:0] OFF_STAT = 2'd1;
    localparam logic [1:0] OFF_DATA = 2'd2;

    localparam logic [1:0] DONE_OK  = 2'd0;
    localparam logic [1:0] DONE_TMO = 2'd1;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [2:0] FLAG_OK  = 3'b100;
    localparam logic [2:0] FLAG_ERR = 3'b010;
    localparam logic [2:0] FLAG_TMO = 3'b001;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  reg_addr;
        logic [31:0] write_value;
        logic [1:0]  done_status;
        logic [3:0]  done_length;
        logic [63:0] done_payload;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] mailbox_status;
        logic        any_busy;
        logic        access_error;
        logic [1:0]  issue_kind;
        logic [15:0] issue_device;
        logic [10:0] issue_register;
        logic        issue_priority;
        logic [2:0]  issue_expected_bytes;
        logic [63:0] issue_payload;
        logic [3:0]  issue_length;
        logic [17:0] interrupt_counts;
    } rsp_t;

    // Per-mailbox state record
    typedef struct packed {
        logic [15:0] dev;
        logic [10:0] rnum;
        logic [2:0]  esize;
        logic        prio;
        logic        busy;
        logic [2:0]  flags;
        logic [63:0] pay;
        logic [2:0]  cur;
        logic [3:0]  cnt;
    } box_t;

    function automatic logic [31:0] status_word(input box_t bx);
        logic [31:0] s;
        s = {28'd0, bx.cnt};
        if (bx.flags[2])      s[23] = 1'b1;
        else if (bx.flags[1]) s[22] = 1'b1;
        else if (bx.flags[0]) s[21] = 1'b1;
        return s;
    endfunction

endpackage

FILE: src/bus_mailbox_register_block.sv
// Top level of the mailbox register block: decode, sequencer, state.
// Depends on bmrb_pkg and bmrb_byte_unit.
//
// Usage: the host drives req with a register write, register read or a
// completion event and pulses start while busy is low. The block then works
// on that transaction and presents the response on rsp with done high for
// exactly one cycle; the receiver cannot stall it.
// Control, status and completion accesses pass through ST_EXEC and ST_RESP
// after acceptance; data accesses also pass through ST_BYTE, where the shared
// byte unit moves one byte per cycle for four bytes. busy is high from
// acceptance until done, so no new transaction is accepted before done.
// Unmapped addresses report access_error and change nothing.
// Reset: asynchronous, active low; all mailbox state clears to zero.
module bus_mailbox_register_block
    import bmrb_pkg::*;
#(
    parameter int MAILBOXES_PER_DIRECTION = MAILBOXES_PER_DIRECTION_DEF,
    parameter int DATA_BYTES = DATA_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_BYTE = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    box_t   box_reg [NUM_BOX];
    logic [31:0] shadow_reg [NUM_BOX];
    req_t   req_reg;
    logic [1:0] step_reg;
    logic [31:0] acc_reg;
    rsp_t   rsp_reg;
    logic   done_reg;

    // address decode on the latched transaction
    logic [3:0] hi;
    logic [1:0] idx, off;
    logic       mapped;
    logic [2:0] bsel;
    assign hi  = req_reg.reg_addr[7:4];
    assign idx = req_reg.reg_addr[3:2];
    assign off = req_reg.reg_addr[1:0];
    assign mapped = (hi == 4'h1 || hi == 4'h2) &&
                    ({1'b0, idx} < 3'(MAILBOXES_PER_DIRECTION));
    assign bsel = {hi == 4'h2, idx};

    box_t cur_box;
    assign cur_box = box_reg[bsel];

    box_t bu_out;
    logic [7:0] rbyte;
    logic [7:0] wbyte;
    assign wbyte = req_reg.write_value[8*(3-step_reg) +: 8];

    bmrb_byte_unit #(.DATA_BYTES(DATA_BYTES)) u_byte (
        .is_write(req_reg.mode == MODE_WRITE),
        .wbyte   (wbyte),
        .box_in  (cur_box),
        .box_out (bu_out),
        .rbyte   (rbyte)
    );

    box_t        box_upd;
    logic [31:0] wv;
    logic [63:0] bmask;
    logic [3:0]  dlen;
    logic        go;
    assign wv = req_reg.write_value;
    assign bmask = ~64'd0 << (8 * (8 - DATA_BYTES));
    assign dlen = (req_reg.done_length > 4'(DATA_BYTES)) ? 4'(DATA_BYTES)
                                                         : req_reg.done_length;
    // control write with GO set starts a transaction
    assign go = mapped && req_reg.mode == MODE_WRITE && off == OFF_CTRL && wv[0];

    always_comb
    begin
        box_upd = cur_box;
        if (req_reg.mode == MODE_WRITE && off == OFF_CTRL)
        begin
            box_upd.dev   = wv[31:16];
            box_upd.rnum  = wv[15:5];
            box_upd.esize = wv[4:2];
            box_upd.prio  = wv[1];
            if (wv[0])
            begin
                box_upd.flags = 3'b000;
                box_upd.busy  = 1'b1;
            end
        end
        else if (req_reg.mode == MODE_WRITE && off == OFF_STAT)
        begin
            if (wv[31])
                box_upd = '0;
            if (wv[23]) box_upd.flags = box_upd.flags & ~FLAG_OK;
            if (wv[22]) box_upd.flags = box_upd.flags & ~FLAG_ERR;
            if (wv[21]) box_upd.flags = box_upd.flags & ~FLAG_TMO;
        end
        else if (req_reg.mode == MODE_DONE)
        begin
            box_upd.busy = 1'b0;
            if (req_reg.done_status == DONE_TMO)
                box_upd.flags = cur_box.flags | FLAG_TMO;
            else if (req_reg.done_status == DONE_OK)
            begin
                box_upd.flags = cur_box.flags | FLAG_OK;
                if (hi == 4'h1)
                begin
                    box_upd.cnt = dlen;
                    box_upd.pay = req_reg.done_payload & bmask;
                end
            end
            else
                box_upd.flags = cur_box.flags | FLAG_ERR;
        end
    end

    logic is_data;
    assign is_data = mapped && off == OFF_DATA &&
                     (req_reg.mode == MODE_WRITE || req_reg.mode == MODE_READ);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_EXEC;
            ST_EXEC: state_next = is_data ? ST_BYTE : ST_RESP;
            ST_BYTE: if (step_reg == 2'd3) state_next = ST_RESP;
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // response build from final state, in ST_RESP
    rsp_t rsp_next;
    logic [17:0] cnt_sum;
    always_comb
    begin
        rsp_next = rsp_reg;
        cnt_sum = '0;
        rsp_next.any_busy = 1'b0;
        for (int k = 0; k < NUM_BOX; k++)
        begin
            if ((k % 4) < MAILBOXES_PER_DIRECTION)
            begin
                if (box_reg[k].busy) rsp_next.any_busy = 1'b1;
                if (box_reg[k].flags[2])
                    cnt_sum = cnt_sum + (18'd1 << ((k / 4) * 9));
                else if (box_reg[k].flags[1])
                    cnt_sum = cnt_sum + (18'd1 << ((k / 4) * 9 + 3));
                else if (box_reg[k].flags[0])
                    cnt_sum = cnt_sum + (18'd1 << ((k / 4) * 9 + 6));
            end
        end
        rsp_next.interrupt_counts = cnt_sum;
        rsp_next.access_error   = !mapped;
        rsp_next.mailbox_status = mapped ? status_word(cur_box) : 32'd0;
        rsp_next.read_data      = '0;
        if (mapped && req_reg.mode == MODE_READ)
        begin
            if (off == OFF_CTRL)      rsp_next.read_data = shadow_reg[bsel];
            else if (off == OFF_STAT) rsp_next.read_data = status_word(cur_box);
            else if (off == OFF_DATA) rsp_next.read_data = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            req_reg   <= '0;
            acc_reg   <= '0;
            rsp_reg   <= '0;
            for (int k = 0; k < NUM_BOX; k++)
            begin
                box_reg[k]    <= '0;
                shadow_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start) req_reg <= req;
                    step_reg <= '0;
                end
                ST_EXEC:
                begin
                    acc_reg <= '0;
                    if (mapped)
                        box_reg[bsel] <= box_upd;
                    if (mapped && req_reg.mode == MODE_WRITE && off == OFF_CTRL)
                        shadow_reg[bsel] <= wv;
                    if (go)
                    begin
                        rsp_reg.issue_kind <= (hi == 4'h1) ? KIND_READ : KIND_WRITE;
                        rsp_reg.issue_device         <= wv[31:16];
                        rsp_reg.issue_register       <= wv[15:5];
                        rsp_reg.issue_priority       <= wv[1];
                        rsp_reg.issue_expected_bytes <= wv[4:2];
                        rsp_reg.issue_payload <= (hi == 4'h2) ? cur_box.pay : 64'd0;
                        rsp_reg.issue_length  <= (hi == 4'h2) ? cur_box.cnt : 4'd0;
                    end
                    else
                    begin
                        rsp_reg.issue_kind           <= KIND_NONE;
                        rsp_reg.issue_device         <= '0;
                        rsp_reg.issue_register       <= '0;
                        rsp_reg.issue_priority       <= 1'b0;
                        rsp_reg.issue_expected_bytes <= '0;
                        rsp_reg.issue_payload        <= '0;
                        rsp_reg.issue_length         <= '0;
                    end
                end
                ST_BYTE:
                begin
                    box_reg[bsel] <= bu_out;
                    acc_reg  <= {acc_reg[23:0], rbyte};
                    step_reg <= step_reg + 2'd1;
                end
                ST_RESP:
                begin
                    rsp_reg  <= rsp_next;
                    done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;
endmodule

FILE: src/bmrb_byte_unit.sv
// Shared byte step unit: moves one data byte and advances the cursor per step.
// Depends on bmrb_pkg.
module bmrb_byte_unit
    import bmrb_pkg::*;
#(
    parameter int DATA_BYTES = DATA_BYTES_DEF
)
(
    input  logic        is_write,
    input  logic [7:0]  wbyte,
    input  box_t        box_in,
    output box_t        box_out,
    output logic [7:0]  rbyte
);
    logic [5:0] sh;
    logic [3:0] nxt;
    logic [3:0] cntn;
    logic [6:0] prod;
    logic [3:0] rmd;

    always_comb
    begin
        box_out = box_in;
        sh = 6'((3'd7 - box_in.cur) * 8);
        rbyte = box_in.pay[sh +: 8];
        nxt = {1'b0, box_in.cur} + 4'd1;
        prod = '0;
        rmd = nxt;
        if (is_write)
        begin
            box_out.pay[sh +: 8] = wbyte;
            box_out.cur = (nxt == 4'(DATA_BYTES)) ? 3'd0 : nxt[2:0];
            cntn = box_in.cnt + 4'd1;
            // count may sit at DATA_BYTES after a completion, so subtract
            box_out.cnt = (cntn >= 4'(DATA_BYTES)) ? cntn - 4'(DATA_BYTES) : cntn;
        end
        else
        begin
            cntn = 4'd0;
            // cursor + 1 modulo count: the largest multiple of count that fits
            // is found by parallel constant multiples, count is at most 8
            for (int q = 1; q <= 8; q++)
            begin
                prod = 7'(q) * {3'b000, box_in.cnt};
                if (prod <= {3'b000, nxt})
                    rmd = nxt - prod[3:0];
            end
            if (box_in.cnt == 4'd0)
                box_out.cur = 3'd0;
            else
                box_out.cur = rmd[2:0];
        end
    end
endmodule

FILE: src/bmrb_checker.sv
// Port-level checker for the mailbox register block, bound to the top level.
// Depends on bmrb_pkg.
module bmrb_checker
    import bmrb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than a cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.access_error |-> rsp.read_data == 32'd0 &&
        rsp.issue_kind == KIND_NONE) else $error("unmapped access had effect");
endmodule

bind bus_mailbox_register_block bmrb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

FILE: tb/sv/bus_mailbox_register_block_test.sv
// Testbench for the mailbox register block: directed and random host accesses,
// checked against a cycle-free model of the mailbox state held in a scoreboard.
// Depends on bmrb_pkg and the bus_mailbox_register_block RTL.
`timescale 1ns / 100ps

class mailbox_scoreboard;
    // model state, per mailbox: 0..3 read, 4..7 write
    bit [15:0] dev [8];
    bit [10:0] rnum [8];
    bit [2:0]  esize [8];
    bit        prio [8];
    bit        inflight [8];
    bit [2:0]  flags [8];
    bit [63:0] pay [8];
    bit [2:0]  cur [8];
    bit [3:0]  cnt [8];
    bit [31:0] ctrl [8];
    bmrb_pkg::rsp_t pending [$];
    int mismatches;

    function void clear_box(int b);
        dev[b] = 0; rnum[b] = 0; esize[b] = 0; prio[b] = 0; inflight[b] = 0;
        flags[b] = 0; pay[b] = 0; cur[b] = 0; cnt[b] = 0;
    endfunction

    function void reset_state();
        for (int b = 0; b < 8; b++)
        begin
            clear_box(b);
            ctrl[b] = 0;
        end
        pending.delete();
        mismatches = 0;
    endfunction

    function bit [31:0] stat_of(int b);
        bit [31:0] s;
        s = {28'd0, cnt[b]};
        if (flags[b][2]) s[23] = 1;
        else if (flags[b][1]) s[22] = 1;
        else if (flags[b][0]) s[21] = 1;
        return s;
    endfunction

    function void note_request(bmrb_pkg::req_t q);
        bmrb_pkg::rsp_t r;
        bit [3:0] hi;
        int idx, off, b, sh;
        bit mapped;
        bit [31:0] wv;
        bit [17:0] ic;
        r = '0;
        hi = q.reg_addr[7:4];
        idx = q.reg_addr[3:2];
        off = q.reg_addr[1:0];
        wv = q.write_value;
        mapped = (hi == 4'h1 || hi == 4'h2);
        b = (hi == 4'h2 ? 4 : 0) + idx;
        if (mapped)
        begin
            if (q.mode == bmrb_pkg::MODE_WRITE)
            begin
                if (off == bmrb_pkg::OFF_CTRL)
                begin
                    dev[b] = wv[31:16]; rnum[b] = wv[15:5]; esize[b] = wv[4:2];
                    prio[b] = wv[1]; ctrl[b] = wv;
                    if (wv[0])
                    begin
                        flags[b] = 0; inflight[b] = 1;
                        r.issue_kind = (hi == 4'h1) ? bmrb_pkg::KIND_READ
                                                   : bmrb_pkg::KIND_WRITE;
                        r.issue_device = dev[b]; r.issue_register = rnum[b];
                        r.issue_priority = prio[b]; r.issue_expected_bytes = esize[b];
                        if (hi == 4'h2)
                        begin
                            r.issue_payload = pay[b]; r.issue_length = cnt[b];
                        end
                    end
                end
                else if (off == bmrb_pkg::OFF_STAT)
                begin
                    if (wv[31]) clear_box(b);
                    if (wv[23]) flags[b] &= ~bmrb_pkg::FLAG_OK;
                    if (wv[22]) flags[b] &= ~bmrb_pkg::FLAG_ERR;
                    if (wv[21]) flags[b] &= ~bmrb_pkg::FLAG_TMO;
                end
                else if (off == bmrb_pkg::OFF_DATA)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        sh = (7 - cur[b]) * 8;
                        pay[b] = (pay[b] & ~(64'hFF << sh))
                               | (64'(wv[(3-i)*8 +: 8]) << sh);
                        cur[b] = (cur[b] + 1) % 8;
                        cnt[b] = (cnt[b] + 1) % 8;
                    end
                end
            end
            else if (q.mode == bmrb_pkg::MODE_READ)
            begin
                if (off == bmrb_pkg::OFF_CTRL) r.read_data = ctrl[b];
                else if (off == bmrb_pkg::OFF_STAT) r.read_data = stat_of(b);
                else if (off == bmrb_pkg::OFF_DATA)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        r.read_data = {r.read_data[23:0], pay[b][(7 - cur[b]) * 8 +: 8]};
                        if (cnt[b] == 0) cur[b] = 0;
                        else cur[b] = (cur[b] + 1) % cnt[b];
                    end
                end
            end
            else if (q.mode == bmrb_pkg::MODE_DONE)
            begin
                if (q.done_status == bmrb_pkg::DONE_TMO) flags[b] |= bmrb_pkg::FLAG_TMO;
                else if (q.done_status == bmrb_pkg::DONE_OK)
                begin
                    flags[b] |= bmrb_pkg::FLAG_OK;
                    if (hi == 4'h1)
                    begin
                        cnt[b] = q.done_length > 8 ? 4'd8 : q.done_length;
                        pay[b] = q.done_payload;
                    end
                end
                else flags[b] |= bmrb_pkg::FLAG_ERR;
                inflight[b] = 0;
            end
            r.mailbox_status = stat_of(b);
        end
        else r.access_error = 1;
        ic = 0;
        for (int k = 0; k < 8; k++)
        begin
            if (inflight[k]) r.any_busy = 1;
            if (flags[k][2]) ic += 18'(1) << ((k / 4) * 9);
            else if (flags[k][1]) ic += 18'(1) << ((k / 4) * 9 + 3);
            else if (flags[k][0]) ic += 18'(1) << ((k / 4) * 9 + 6);
        end
        r.interrupt_counts = ic;
        pending.push_back(r);
    endfunction

    function void check_response(bmrb_pkg::rsp_t got);
        bmrb_pkg::rsp_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module bus_mailbox_register_block_test;
    import bmrb_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    req_t req = '0;
    logic busy, done;
    rsp_t rsp;
    mailbox_scoreboard board;
    int idle_cycles = 0;

    bus_mailbox_register_block DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .req(req),
        .busy(busy), .done(done), .rsp(rsp)
    );

    always #5 clk = ~clk;

    // Result monitor; the receiver cannot stall, so every strobe is a result.
    always @(posedge clk)
    begin
        if (rst_n && done) board.check_response(rsp);
        if (rst_n && !(start && !busy) && !done) idle_cycles++;
        else idle_cycles = 0;
        if (idle_cycles > 5000)
        begin
            $display("bus_mailbox_register_block_test: FAIL");
            $finish;
        end
    end

    // Drive one transaction and hold start until it is accepted.
    // start stays high afterwards; the caller drops it before any pause.
    task automatic send_transaction(req_t q);
        req <= q;
        start <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(q);
    endtask

    function automatic req_t make_req(logic [1:0] m, logic [7:0] a, logic [31:0] v);
        req_t q;
        q = '0;
        q.mode = m; q.reg_addr = a; q.write_value = v;
        return q;
    endfunction

    function automatic req_t random_req();
        req_t q;
        int pick;
        q.mode = $urandom_range(0, 9) < 9 ? 2'($urandom_range(0, 2)) : 2'd3;
        pick = $urandom_range(0, 19);
        // mostly mapped mailboxes, some noise addresses
        if (pick < 18)
            q.reg_addr = {($urandom_range(0, 1) ? 4'h2 : 4'h1),
                          2'($urandom_range(0, 3)), 2'($urandom_range(0, 3))};
        else q.reg_addr = 8'($urandom);
        q.write_value = $urandom;
        if (q.mode == MODE_WRITE && q.reg_addr[1:0] == OFF_STAT && $urandom_range(0, 3) != 0)
            q.write_value[31] = 0;
        q.done_status = 2'($urandom);
        q.done_length = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 8));
        q.done_payload = {$urandom, $urandom};
        return q;
    endfunction

    initial
    begin
        req_t q;
        int gap;
        board = new();
        board.reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, each offset, GO on both directions, completions.
        send_transaction(make_req(MODE_WRITE, 8'h12, 32'hFFFF_FFFF));
        send_transaction(make_req(MODE_WRITE, 8'h12, 32'h0123_4567));
        send_transaction(make_req(MODE_READ, 8'h12, 0));
        send_transaction(make_req(MODE_READ, 8'h12, 0));
        send_transaction(make_req(MODE_WRITE, 8'h20, 32'hFFFF_FFFF));
        send_transaction(make_req(MODE_WRITE, 8'h10, 32'h0000_0001));
        q = make_req(MODE_DONE, 8'h11, 0);
        q.done_status = DONE_OK; q.done_length = 4'hF; q.done_payload = '1;
        send_transaction(q);
        send_transaction(make_req(MODE_READ, 8'h12, 0));
        send_transaction(make_req(MODE_READ, 8'h11, 0));
        q.reg_addr = 8'h20; q.done_status = 2'd3; send_transaction(q);
        q.reg_addr = 8'h2C; q.done_status = DONE_TMO; send_transaction(q);
        q.reg_addr = 8'h14; q.done_length = 0; q.done_status = DONE_OK; send_transaction(q);
        send_transaction(make_req(MODE_READ, 8'h16, 0));
        send_transaction(make_req(MODE_READ, 8'h10, 0));
        send_transaction(make_req(MODE_WRITE, 8'h03, 32'hFFFF_FFFF));
        send_transaction(make_req(MODE_READ, 8'h13, 0));
        send_transaction(make_req(MODE_WRITE, 8'h13, 32'hFFFF_FFFF));
        send_transaction(make_req(2'd3, 8'h1D, 32'hFFFF_FFFF));
        send_transaction(make_req(MODE_WRITE, 8'h21, 32'h00E0_0000));
        send_transaction(make_req(MODE_WRITE, 8'h11, 32'h8000_0000));
        send_transaction(make_req(MODE_READ, 8'hFF, 0));
        send_transaction(make_req(MODE_READ, 8'h00, 0));

        // Random bursts with random gaps.
        for (int n = 0; n < 1200; )
        begin
            int burst;
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++, n++) send_transaction(random_req());
            start <= 0;
            @(posedge clk);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            if (n % 300 < burst)
                while (board.pending.size() != 0) @(posedge clk);
        end

        while (board.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("bus_mailbox_register_block_test: PASS");
        else
            $display("bus_mailbox_register_block_test: FAIL");
        $finish;
    end
endmodule

FILE: filelist.f
src/bmrb_pkg.sv
src/bmrb_byte_unit.sv
src/bus_mailbox_register_block.sv
src/bmrb_checker.sv
tb/sv/bus_mailbox_register_block_test.sv
